/* rtl/core/tgpn_pkg.sv */
package tgpn_pkg;

  // Panel geometry and page ring
  localparam int unsigned PAGE_TOTAL    = 7;
  localparam int unsigned SCREEN_WIDTH  = 240;
  localparam int unsigned SCREEN_HEIGHT = 320;
  localparam int unsigned RADIO_PAGE    = 2;
  localparam int unsigned BUS_PAGE      = 6;

  // Field widths
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned COORD_W    = 9;
  localparam int unsigned PAGE_W     = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic               RST_TOUCH_EN    = 1'b1;
  localparam logic [TMO_W-1:0]   RST_TIMEOUT     = 16'd140;
  localparam logic [COORD_W-1:0] RST_SWIPE_X_MIN = 9'd45;
  localparam logic [COORD_W-1:0] RST_SWIPE_Y_MIN = 9'd70;
  localparam logic [COORD_W-1:0] RST_TOP_BAND    = 9'd58;
  localparam logic [COORD_W-1:0] RST_LEFT_EDGE   = 9'd80;
  localparam logic [COORD_W-1:0] RST_RIGHT_EDGE  = 9'd160;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_BACK    = 3'd2,
    EV_FORWARD = 3'd3,
    EV_REDRAW  = 3'd4,
    EV_RADIO   = 3'd5,
    EV_BUS     = 3'd6
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOUCH_EN    = 3'd0,
    CFG_TIMEOUT     = 3'd1,
    CFG_SWIPE_X_MIN = 3'd2,
    CFG_SWIPE_Y_MIN = 3'd3,
    CFG_TOP_BAND    = 3'd4,
    CFG_LEFT_EDGE   = 3'd5,
    CFG_RIGHT_EDGE  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic               touch_enable;
    logic [TMO_W-1:0]   release_timeout_ms;
    logic [COORD_W-1:0] swipe_x_min;
    logic [COORD_W-1:0] swipe_y_min;
    logic [COORD_W-1:0] top_band_height;
    logic [COORD_W-1:0] left_edge;
    logic [COORD_W-1:0] right_edge;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
  } press_t;

endpackage

/* rtl/core/tgpn_poll_if.sv */
interface tgpn_poll_if;
  logic        valid;
  logic        ready;
  logic        contact;
  logic [11:0] raw_x;
  logic [11:0] raw_y;
  logic [31:0] time_ms;

  modport source (output valid, contact, raw_x, raw_y, time_ms, input ready);
  modport sink   (input valid, contact, raw_x, raw_y, time_ms, output ready);
endinterface

/* rtl/core/tgpn_res_if.sv */
interface tgpn_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  page;
  logic        haptic;
  logic [31:0] press_count;

  modport source (output valid, event_res, page, haptic, press_count, input ready);
  modport sink   (input valid, event_res, page, haptic, press_count, output ready);
endinterface

/* rtl/core/tgpn_classify.sv */
module tgpn_classify (
  input  tgpn_pkg::press_t                press_i,
  input  tgpn_pkg::cfg_t                  cfg_i,
  input  logic [tgpn_pkg::PAGE_W-1:0]     page_i,
  output tgpn_pkg::event_e                event_o,
  output logic [tgpn_pkg::PAGE_W-1:0]     page_o
);
  import tgpn_pkg::*;

  logic [COORD_W-1:0] ax;
  logic [COORD_W-1:0] ay;
  logic               moved_left;
  logic [PAGE_W-1:0]  page_fwd;
  logic [PAGE_W-1:0]  page_back;

  // page index never leaves the ring, so no reduction is needed before stepping
  assign page_fwd  = (page_i == PAGE_W'(PAGE_TOTAL - 1)) ? '0 : page_i + PAGE_W'(1);
  assign page_back = (page_i == '0) ? PAGE_W'(PAGE_TOTAL - 1) : page_i - PAGE_W'(1);

  assign moved_left = press_i.last_x < press_i.start_x;
  assign ax = moved_left ? press_i.start_x - press_i.last_x
                         : press_i.last_x - press_i.start_x;
  assign ay = (press_i.last_y >= press_i.start_y) ? press_i.last_y - press_i.start_y
                                                  : press_i.start_y - press_i.last_y;

  always_comb begin
    event_o = EV_REDRAW;
    page_o  = page_i;
    priority if ((ax >= cfg_i.swipe_x_min) && (ax > ay)) begin
      // swipe to the left turns the page forward
      event_o = moved_left ? EV_FORWARD : EV_BACK;
      page_o  = moved_left ? page_fwd : page_back;
    end else if ((ay >= cfg_i.swipe_y_min) && (ay > ax)) begin
      event_o = EV_REDRAW;
    end else if (press_i.last_y < cfg_i.top_band_height) begin
      priority if (press_i.last_x < cfg_i.left_edge) begin
        event_o = EV_BACK;
        page_o  = page_back;
      end else if (press_i.last_x > cfg_i.right_edge) begin
        event_o = EV_FORWARD;
        page_o  = page_fwd;
      end else begin
        event_o = EV_REDRAW;
      end
    end else if (page_i == PAGE_W'(RADIO_PAGE)) begin
      event_o = EV_RADIO;
    end else if (page_i == PAGE_W'(BUS_PAGE)) begin
      event_o = EV_BUS;
    end else begin
      event_o = EV_REDRAW;
    end
  end

endmodule

/* rtl/core/touch_gesture_page_navigator_core.sv */
// Touch gesture page navigator.
// Pipeline: a poll is held in the input register; its result then loads into the result
// register, from which it transfers when the receiver is ready. Throughput: one poll per cycle
// while the receiver keeps up; the press state updates in one pass of compare logic.
// Reset (async, active low) clears the press tracker, page, counter and both pipeline stages,
// and loads the configuration registers with their default thresholds.
module touch_gesture_page_navigator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tgpn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tgpn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tgpn_poll_if.sink                       poll_i,
  tgpn_res_if.source                      res_o
);
  import tgpn_pkg::*;

  cfg_t cfg_q, cfg_d;

  // input register
  logic               s1_valid_q;
  logic               s1_contact_q;
  logic [RAW_W-1:0]   s1_x_q;
  logic [RAW_W-1:0]   s1_y_q;
  logic [TIME_W-1:0]  s1_time_q;
  logic               s1_adv;
  logic               in_xfer;
  logic               s2_fire;

  // press state
  logic               tracking_q, tracking_d;
  press_t             press_q, press_d;
  logic [TIME_W-1:0]  last_time_q, last_time_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic [TIME_W-1:0]  count_q, count_d;

  // result register
  logic               res_valid_q, res_valid_d;
  event_e             res_event_q;
  logic [PAGE_W-1:0]  res_page_q;
  logic               res_haptic_q;
  logic [TIME_W-1:0]  res_count_q;

  logic               accepted;
  logic [TIME_W-1:0]  elapsed;
  logic               timed_out;
  event_e             ev;
  event_e             cls_event;
  logic [PAGE_W-1:0]  cls_page;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TOUCH_EN:    cfg_d.touch_enable       = cfg_wdata_i[0];
        CFG_TIMEOUT:     cfg_d.release_timeout_ms = cfg_wdata_i[TMO_W-1:0];
        CFG_SWIPE_X_MIN: cfg_d.swipe_x_min        = cfg_wdata_i[COORD_W-1:0];
        CFG_SWIPE_Y_MIN: cfg_d.swipe_y_min        = cfg_wdata_i[COORD_W-1:0];
        CFG_TOP_BAND:    cfg_d.top_band_height    = cfg_wdata_i[COORD_W-1:0];
        CFG_LEFT_EDGE:   cfg_d.left_edge          = cfg_wdata_i[COORD_W-1:0];
        CFG_RIGHT_EDGE:  cfg_d.right_edge         = cfg_wdata_i[COORD_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_enable       <= RST_TOUCH_EN;
      cfg_q.release_timeout_ms <= RST_TIMEOUT;
      cfg_q.swipe_x_min        <= RST_SWIPE_X_MIN;
      cfg_q.swipe_y_min        <= RST_SWIPE_Y_MIN;
      cfg_q.top_band_height    <= RST_TOP_BAND;
      cfg_q.left_edge          <= RST_LEFT_EDGE;
      cfg_q.right_edge         <= RST_RIGHT_EDGE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- handshake ----------------
  assign s1_adv       = !res_valid_q || res_o.ready;
  assign poll_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer      = poll_i.valid && poll_i.ready;
  assign s2_fire      = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      s1_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_contact_q <= poll_i.contact;
      s1_x_q       <= poll_i.raw_x;
      s1_y_q       <= poll_i.raw_y;
      s1_time_q    <= poll_i.time_ms;
    end
  end

  // ---------------- press tracking ----------------
  assign accepted = s1_contact_q && cfg_q.touch_enable &&
                    (s1_x_q < RAW_W'(SCREEN_WIDTH)) && (s1_y_q < RAW_W'(SCREEN_HEIGHT));
  assign elapsed   = s1_time_q - last_time_q;
  assign timed_out = elapsed >= TIME_W'(cfg_q.release_timeout_ms);

  tgpn_classify u_classify (
    .press_i (press_q),
    .cfg_i   (cfg_q),
    .page_i  (page_q),
    .event_o (cls_event),
    .page_o  (cls_page)
  );

  always_comb begin
    tracking_d  = tracking_q;
    press_d     = press_q;
    last_time_d = last_time_q;
    page_d      = page_q;
    count_d     = count_q;
    ev          = EV_NONE;
    if (accepted) begin
      count_d        = count_q + TIME_W'(1);
      last_time_d    = s1_time_q;
      press_d.last_x = s1_x_q[COORD_W-1:0];
      press_d.last_y = s1_y_q[COORD_W-1:0];
      if (!tracking_q) begin
        press_d.start_x = s1_x_q[COORD_W-1:0];
        press_d.start_y = s1_y_q[COORD_W-1:0];
        tracking_d      = 1'b1;
        ev              = EV_PRESS;
      end
    end else if (tracking_q && timed_out) begin
      tracking_d = 1'b0;
      ev         = cls_event;
      page_d     = cls_page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q  <= 1'b0;
      press_q     <= '0;
      last_time_q <= '0;
      page_q      <= '0;
      count_q     <= '0;
    end else if (s2_fire) begin
      tracking_q  <= tracking_d;
      press_q     <= press_d;
      last_time_q <= last_time_d;
      page_q      <= page_d;
      count_q     <= count_d;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    res_valid_d = res_valid_q;
    if (s2_fire) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      res_event_q  <= ev;
      res_page_q   <= page_d;
      res_haptic_q <= (ev != EV_NONE);
      res_count_q  <= count_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.event_res   = res_event_q;
  assign res_o.page        = res_page_q;
  assign res_o.haptic      = res_haptic_q;
  assign res_o.press_count = res_count_q;

  // ---------------- assertions ----------------
  a_haptic_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.haptic == (res_o.event_res != EV_NONE)))
    else $error("haptic flag disagrees with event code");

  a_page_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.page <= PAGE_W'(PAGE_TOTAL - 1)))
    else $error("page index outside the ring");

  a_page_moves_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (page_q != $past(page_q)) |-> $past(s2_fire && (ev == EV_BACK || ev == EV_FORWARD)))
    else $error("page changed without a page step");

  a_press_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && ev == EV_PRESS) |=> (count_q == $past(count_q) + TIME_W'(1)))
    else $error("press start without a counted contact");

endmodule
